[sv/bqb_pkg.sv]
// Shared types and constants for the Bayer quad binning block.
// No dependencies; imported by bayer_quad_bin_to_rgb.
package bqb_pkg;

  // Port widths fixed by the interface
  localparam int SAMPLE_W      = 16;
  localparam int GREEN_W       = 17;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 12;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PAIRS_PER_ROW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOSAIC_PHASE  = 2'd1;

  // Color order at row0col0, row0col1, row1col0, row1col1
  typedef enum logic [1:0] {
    PH_GBRG = 2'd0,
    PH_RGGB = 2'd1,
    PH_GRBG = 2'd2,
    PH_BGGR = 2'd3
  } phase_t;

endpackage

[sv/bqb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bqb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/bayer_quad_bin_to_rgb.sv]
// Bayer 2x2 quad binning to half-resolution RGB, top level.
// Uses bqb_pkg and two bqb_ram line-store halves.
//
// Throughput: one sample per clock, sustained, with out_ready held high.
// After the transfer of a quad's last (odd row, odd column) sample, the
//   line-store read loads the read stage, and the output register then
//   takes the result and raises out_valid.
// Reset (rst, synchronous): clears column, row parity, held sample and both
//   valid flags, and loads the register defaults (2048 pairs, clamped to
//   MAX_ROW_PIXELS/2; RGGB). The line store is not cleared; every entry is
//   written on an even row before the following odd row reads it.
module bayer_quad_bin_to_rgb #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bqb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bqb_pkg::CFG_DATA_W-1:0]    cfg_data,
  // raw sample stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bqb_pkg::SAMPLE_W-1:0]      sample,
  input  logic                              frame_start,
  // RGB pixel stream
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bqb_pkg::SAMPLE_W-1:0]      blue,
  output logic [bqb_pkg::GREEN_W-1:0]       green_twice,
  output logic [bqb_pkg::SAMPLE_W-1:0]      red,
  output logic                              row_end
);

  import bqb_pkg::*;

  // Column counter spans one full row; the store is split into an even-column
  // half and an odd-column half so one quad reads both top samples at once.
  localparam int CW         = (MAX_ROW_PIXELS > 2) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int HALF       = MAX_ROW_PIXELS / 2;
  localparam int DEPTH      = (MAX_ROW_PIXELS + 1) / 2;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RESET_LAST = 2 * ((2048 > HALF) ? HALF : 2048) - 1;

  // Configuration state: last column index of a row, and the mosaic order
  logic [CW-1:0]          last_col;
  phase_t                 phase;
  logic [31:0]            pairs_req;

  // Raster position
  logic [CW-1:0]          col;
  logic                   odd;
  logic [SAMPLE_BITS-1:0] held;

  // Current item, with frame start applied
  logic [SAMPLE_BITS-1:0] s_in;
  logic [CW-1:0]          cur_col;
  logic                   cur_odd;
  logic                   at_last;
  logic [AW-1:0]          pair_addr;
  logic                   in_fire;
  logic                   we_even;
  logic                   we_odd;
  logic                   rd_en;

  // Read stage: holds the bottom samples while the store read completes
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_c;
  logic [SAMPLE_BITS-1:0] s1_d;
  logic                   s1_end;
  logic                   s1_adv;
  logic [SAMPLE_BITS-1:0] top_a;
  logic [SAMPLE_BITS-1:0] top_b;

  // Assembled pixel
  logic [SAMPLE_W-1:0]    blue_next;
  logic [GREEN_W-1:0]     green_next;
  logic [SAMPLE_W-1:0]    red_next;

  // ---------------------------------------------------------------------
  // Configuration: always ready; clamp the width once at write time so the
  // row-end compare is a single magnitude compare on the column.
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    pairs_req = 32'(cfg_data);
    if (pairs_req == 32'd0) begin
      pairs_req = 32'd1;
    end else if (pairs_req > 32'(HALF)) begin
      pairs_req = 32'(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= CW'(RESET_LAST);
      phase    <= PH_RGGB;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAIRS_PER_ROW: last_col <= CW'((pairs_req << 1) - 32'd1);
        REG_MOSAIC_PHASE:  phase    <= phase_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input side: frame start forces row 0, column 0. A row ends once the
  // column reaches the last column or lies past it (width changed mid-row).
  // ---------------------------------------------------------------------
  assign s_in      = sample[SAMPLE_BITS-1:0];
  assign cur_col   = frame_start ? '0 : col;
  assign cur_odd   = frame_start ? 1'b0 : odd;
  assign at_last   = (cur_col >= last_col);
  assign pair_addr = AW'(cur_col >> 1);

  // Accept while the read stage is free or drains into the output register
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Even rows write the store; odd rows read it on odd columns. Reads and
  // writes never share a cycle, and every read follows the matching write by
  // at least a row, so no forwarding is needed.
  assign we_even = in_fire && !cur_odd && !cur_col[0];
  assign we_odd  = in_fire && !cur_odd &&  cur_col[0];
  assign rd_en   = in_fire &&  cur_odd &&  cur_col[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      odd  <= 1'b0;
      held <= '0;
    end else if (in_fire) begin
      col <= at_last ? '0 : cur_col + CW'(1);
      odd <= at_last ? !cur_odd : cur_odd;
      // hold the bottom-left sample of the quad
      if (cur_odd && !cur_col[0]) begin
        held <= s_in;
      end
    end
  end

  bqb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (pair_addr),
    .wdata (s_in),
    .re    (rd_en),
    .raddr (pair_addr),
    .rdata (top_a)
  );

  bqb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (pair_addr),
    .wdata (s_in),
    .re    (rd_en),
    .raddr (pair_addr),
    .rdata (top_b)
  );

  // ---------------------------------------------------------------------
  // Read stage. The RAM outputs only change on a new read, and a new read
  // only happens on a transfer, so they stay put while this stage stalls.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_c   <= held;
      s1_d   <= s_in;
      s1_end <= at_last;
    end
  end

  // Sort the four quad samples into colors by mosaic order
  always_comb begin
    case (phase)
      PH_GBRG: begin
        blue_next  = SAMPLE_W'(top_b);
        green_next = GREEN_W'(top_a) + GREEN_W'(s1_d);
        red_next   = SAMPLE_W'(s1_c);
      end
      PH_RGGB: begin
        blue_next  = SAMPLE_W'(s1_d);
        green_next = GREEN_W'(top_b) + GREEN_W'(s1_c);
        red_next   = SAMPLE_W'(top_a);
      end
      PH_GRBG: begin
        blue_next  = SAMPLE_W'(s1_c);
        green_next = GREEN_W'(top_a) + GREEN_W'(s1_d);
        red_next   = SAMPLE_W'(top_b);
      end
      default: begin
        blue_next  = SAMPLE_W'(top_a);
        green_next = GREEN_W'(top_b) + GREEN_W'(s1_c);
        red_next   = SAMPLE_W'(s1_d);
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register: load from the read stage, drop on transfer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      blue        <= blue_next;
      green_twice <= green_next;
      red         <= red_next;
      row_end     <= s1_end;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && (we_even || we_odd)))
    else $error("line store read and write in the same cycle");

  a_read_fills_stage: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> s1_valid)
    else $error("store read without a loaded read stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_d) && $stable(top_a)
                               && $stable(top_b)))
    else $error("read stage lost data while stalled");

  a_parity_mid_row: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !frame_start && !at_last) |=> (odd == $past(odd)))
    else $error("row parity changed inside a row");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted with both stages blocked");

endmodule
